### src/hsv2rgb_pkg.sv
// ----------------------------------------------------------------------------
// hsv2rgb_pkg: shared types and constants of the HSV to RGB converter
// Pixel beat formats, stage bundles, sector codes and the fixed-point
// reciprocals used for the rounding divisions.
// ----------------------------------------------------------------------------
package hsv2rgb_pkg;

  // Beat formats on the ports
  typedef struct packed {
    logic [8:0] hue_deg;
    logic [7:0] sat;
    logic [7:0] val;
    logic [7:0] alpha_in;
  } hsv_pix_t;

  typedef struct packed {
    logic [7:0] red_out;
    logic [7:0] green_out;
    logic [7:0] blue_out;
    logic [7:0] alpha_out;
  } rgb_pix_t;

  // Arithmetic constants
  localparam logic [8:0]  SECTOR_DEG = 9'd60;
  localparam int          MAX_SECTOR = 8;
  localparam logic [7:0]  ONE        = 8'd255;
  localparam logic [13:0] SCALE      = 14'd15300;
  localparam logic [16:0] HALF_ONE   = 17'd127;
  localparam logic [21:0] HALF_SCALE = 22'd7650;

  // floor(x / 255) = (x * P_RECIP) >> P_SHIFT for x < 2^16 - 255
  localparam logic [16:0] P_RECIP = 17'd65794;
  localparam int          P_SHIFT = 24;
  // floor(x / 15300) = (x * Q_RECIP) >> Q_SHIFT for x < 2^22
  localparam logic [22:0] Q_RECIP = 23'd4491470;
  localparam int          Q_SHIFT = 36;

  // Hue sectors (60 degrees each); codes above SEC_BLUE (the magenta sector
  // and hues past 359) use the default row
  localparam logic [3:0] SEC_RED     = 4'd0;
  localparam logic [3:0] SEC_YELLOW  = 4'd1;
  localparam logic [3:0] SEC_GREEN   = 4'd2;
  localparam logic [3:0] SEC_CYAN    = 4'd3;
  localparam logic [3:0] SEC_BLUE    = 4'd4;

  // Stage bundles
  typedef struct packed {
    logic [3:0] sector;
    logic [5:0] k;
    logic [7:0] sat;
    logic [7:0] val;
    logic [7:0] alpha;
  } s1_t;

  typedef struct packed {
    logic [3:0]  sector;
    logic [7:0]  val;
    logic [7:0]  alpha;
    logic [16:0] p_num;
    logic [13:0] qd;
    logic [13:0] td;
  } s2_t;

  typedef struct packed {
    logic [3:0]  sector;
    logic [7:0]  val;
    logic [7:0]  alpha;
    logic [16:0] p_num;
    logic [21:0] q_num;
    logic [21:0] t_num;
  } s3_t;

  typedef struct packed {
    logic [3:0] sector;
    logic [7:0] val;
    logic [7:0] alpha;
    logic [7:0] p;
    logic [7:0] q;
    logic [7:0] t;
  } s4_t;

endpackage

### src/hsv2rgb_sector.sv
// ----------------------------------------------------------------------------
// hsv2rgb_sector: hue split stage
// Splits the hue into its 60-degree sector and the offset inside it.
// ----------------------------------------------------------------------------
module hsv2rgb_sector
  import hsv2rgb_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     en,
  input  logic     vld_in,
  input  hsv_pix_t pix_in,
  output logic     vld_out,
  output s1_t      s1_out
);

  logic       vld_r;
  s1_t        s1_r;
  s1_t        s1_nxt;
  logic [3:0] sector;
  logic [8:0] base;

  // Parallel compares against the sector boundaries
  always_comb begin
    sector = SEC_RED;
    for (int i = 1; i <= MAX_SECTOR; i++) begin
      if (pix_in.hue_deg >= 9'(i * 60)) begin
        sector = 4'(i);
      end
    end
  end

  assign base = 9'(sector) * SECTOR_DEG;

  always_comb begin
    s1_nxt.sector = sector;
    s1_nxt.k      = 6'(pix_in.hue_deg - base);
    s1_nxt.sat    = pix_in.sat;
    s1_nxt.val    = pix_in.val;
    s1_nxt.alpha  = pix_in.alpha_in;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= vld_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_r <= s1_nxt;
    end
  end

  assign vld_out = vld_r;
  assign s1_out  = s1_r;

endmodule

### src/hsv2rgb_levels.sv
// ----------------------------------------------------------------------------
// hsv2rgb_levels: numerator stages
// Two register stages that build the rounded numerators of p, q and t.
// ----------------------------------------------------------------------------
module hsv2rgb_levels
  import hsv2rgb_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic en,
  input  logic vld_in,
  input  s1_t  s1_in,
  output logic vld_out,
  output s3_t  s3_out
);

  logic        vld2_r;
  logic        vld3_r;
  s2_t         s2_r;
  s2_t         s2_nxt;
  s3_t         s3_r;
  s3_t         s3_nxt;
  logic [13:0] sk;
  logic [13:0] sk_inv;

  // Stage 2: saturation products
  assign sk     = 14'(s1_in.sat) * 14'(s1_in.k);
  assign sk_inv = 14'(s1_in.sat) * 14'(6'(SECTOR_DEG) - s1_in.k);

  always_comb begin
    s2_nxt.sector = s1_in.sector;
    s2_nxt.val    = s1_in.val;
    s2_nxt.alpha  = s1_in.alpha;
    s2_nxt.p_num  = 17'(16'(s1_in.val) * 16'(ONE - s1_in.sat)) + HALF_ONE;
    s2_nxt.qd     = SCALE - sk;
    s2_nxt.td     = SCALE - sk_inv;
  end

  // Stage 3: scale by value and add the rounding half
  always_comb begin
    s3_nxt.sector = s2_r.sector;
    s3_nxt.val    = s2_r.val;
    s3_nxt.alpha  = s2_r.alpha;
    s3_nxt.p_num  = s2_r.p_num;
    s3_nxt.q_num  = 22'(s2_r.val) * 22'(s2_r.qd) + HALF_SCALE;
    s3_nxt.t_num  = 22'(s2_r.val) * 22'(s2_r.td) + HALF_SCALE;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld2_r <= 1'b0;
      vld3_r <= 1'b0;
    end else if (en) begin
      vld2_r <= vld_in;
      vld3_r <= vld2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_r <= s2_nxt;
      s3_r <= s3_nxt;
    end
  end

  assign vld_out = vld3_r;
  assign s3_out  = s3_r;

endmodule

### src/hsv2rgb_div.sv
// ----------------------------------------------------------------------------
// hsv2rgb_div: constant division stage
// Divides the numerators by 255 and 15300 through reciprocal multiplies.
// ----------------------------------------------------------------------------
module hsv2rgb_div
  import hsv2rgb_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic en,
  input  logic vld_in,
  input  s3_t  s3_in,
  output logic vld_out,
  output s4_t  s4_out
);

  logic        vld_r;
  logic [3:0]  sector_r;
  logic [7:0]  val_r;
  logic [7:0]  alpha_r;
  logic [33:0] p_prod_r;
  logic [44:0] q_prod_r;
  logic [44:0] t_prod_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= vld_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sector_r <= s3_in.sector;
      val_r    <= s3_in.val;
      alpha_r  <= s3_in.alpha;
      p_prod_r <= 34'(s3_in.p_num) * 34'(P_RECIP);
      q_prod_r <= 45'(s3_in.q_num) * 45'(Q_RECIP);
      t_prod_r <= 45'(s3_in.t_num) * 45'(Q_RECIP);
    end
  end

  // Quotients all fit in 8 bits
  assign vld_out       = vld_r;
  assign s4_out.sector = sector_r;
  assign s4_out.val    = val_r;
  assign s4_out.alpha  = alpha_r;
  assign s4_out.p      = p_prod_r[P_SHIFT +: 8];
  assign s4_out.q      = q_prod_r[Q_SHIFT +: 8];
  assign s4_out.t      = t_prod_r[Q_SHIFT +: 8];

endmodule

### src/hsv_to_rgb_converter.sv
// ----------------------------------------------------------------------------
// hsv_to_rgb_converter: HSV to RGB pixel converter
// Converts one HSV pixel with alpha to its RGB color every clock unless stalled.
// ----------------------------------------------------------------------------
// Usage:
//   in_valid/in_ready/in_data carry one HSV pixel per beat (hue in degrees,
//   saturation, value and alpha as 8-bit fractions of 255).
//   out_valid/out_ready/out_data carry the RGB pixel with alpha copied.
//   An accepted input beat reaches out_valid through the sector
//   split, saturation products, value products, reciprocal divide, and the
//   sector routing into the output register.
//   Throughput is one pixel per cycle unless stalled; the five register
//   stages advance together, so new beats enter while others are in flight.
//   When the receiver stalls with a result waiting, the whole pipeline holds
//   and in_ready drops in the same cycle; nothing is dropped or repeated, and
//   empty stages do not fill while stalled.
//   Zero saturation needs no special path: p, q and t all round to the value,
//   which yields grey. Hues of 360 and above route through the default row.
//   Synchronous active-low reset clears every stage's valid bit; payload
//   registers are not reset.
// ----------------------------------------------------------------------------
module hsv_to_rgb_converter
  import hsv2rgb_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  hsv_pix_t in_data,
  output logic     out_valid,
  input  logic     out_ready,
  output rgb_pix_t out_data
);

  logic     en;
  logic     vld1;
  logic     vld3;
  logic     vld4;
  s1_t      s1;
  s3_t      s3;
  s4_t      s4;
  logic     out_vld_r;
  rgb_pix_t out_r;
  rgb_pix_t out_nxt;

  // Advance every stage unless a finished result waits on the receiver
  assign en       = !out_vld_r || out_ready;
  assign in_ready = en;

  hsv2rgb_sector u_sector (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .vld_in  (in_valid),
    .pix_in  (in_data),
    .vld_out (vld1),
    .s1_out  (s1)
  );

  hsv2rgb_levels u_levels (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .vld_in  (vld1),
    .s1_in   (s1),
    .vld_out (vld3),
    .s3_out  (s3)
  );

  hsv2rgb_div u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .vld_in  (vld3),
    .s3_in   (s3),
    .vld_out (vld4),
    .s4_out  (s4)
  );

  // Route v, p, q and t to the channels by sector
  always_comb begin
    out_nxt.alpha_out = s4.alpha;
    case (s4.sector)
      SEC_RED: begin
        out_nxt.red_out   = s4.val;
        out_nxt.green_out = s4.t;
        out_nxt.blue_out  = s4.p;
      end
      SEC_YELLOW: begin
        out_nxt.red_out   = s4.q;
        out_nxt.green_out = s4.val;
        out_nxt.blue_out  = s4.p;
      end
      SEC_GREEN: begin
        out_nxt.red_out   = s4.p;
        out_nxt.green_out = s4.val;
        out_nxt.blue_out  = s4.t;
      end
      SEC_CYAN: begin
        out_nxt.red_out   = s4.p;
        out_nxt.green_out = s4.q;
        out_nxt.blue_out  = s4.val;
      end
      SEC_BLUE: begin
        out_nxt.red_out   = s4.t;
        out_nxt.green_out = s4.p;
        out_nxt.blue_out  = s4.val;
      end
      default: begin
        // Magenta sector, and any hue past 359
        out_nxt.red_out   = s4.val;
        out_nxt.green_out = s4.p;
        out_nxt.blue_out  = s4.q;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (en) begin
      out_vld_r <= vld4;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_r <= out_nxt;
    end
  end

  assign out_valid = out_vld_r;
  assign out_data  = out_r;

endmodule
